// File: sv/mbp_pkg.sv
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared types and constants of the MSB-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

   localparam int WORD_BITS  = 32;
   localparam int POS_W      = 5;    // bit position inside a word
   localparam int COUNT_W    = 10;   // bit_count field
   localparam int TOTAL_W    = 17;   // bits_written / max_bits
   localparam int IDX_W      = 11;   // word_index field
   localparam int WORDS_W    = 6;    // words one skip can complete (up to 32)
   localparam int SHIFT_W    = 7;    // shift over the two-word window

   localparam logic [TOTAL_W-1:0] LIMIT_RESET = 17'd65536;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_SKIP  = 2'd1,
      CMD_RESET = 2'd2,
      CMD_FLUSH = 2'd3
   } cmd_type;

endpackage

// File: sv/msb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Appends values of 1 to 32 bits, or runs of zero bits, MSB first into
// 32-bit words and returns every completed or flushed word with its buffer index.
// ----------------------------------------------------------------------------
// A transaction is registered, executed in ST_EXEC, and its result presented from
//   the output register. A new one is taken only in ST_IDLE with the output free;
//   a multi-word skip stays in ST_EMIT, one extra word per cycle while not stalled.
// The sequencer holds one transaction at a time around a single shift/merge unit.
// Reset (synchronous): empty buffer, max_bits = 65536, no result pending.
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
   parameter int CAPACITY_BITS = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [mbp_pkg::TOTAL_W-1:0]   csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [mbp_pkg::WORD_BITS-1:0] req_value,
   input  logic [mbp_pkg::COUNT_W-1:0]   req_bit_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic                          rsp_word_valid,
   output logic [mbp_pkg::WORD_BITS-1:0] rsp_word,
   output logic [mbp_pkg::IDX_W-1:0]     rsp_word_index,
   output logic [mbp_pkg::TOTAL_W-1:0]   rsp_bits_written,
   output logic                          rsp_last
);
   import mbp_pkg::*;

   localparam int CAP_W = 21;
   localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAPACITY_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [TOTAL_W-1:0]   max_bits_ff, max_bits_in;
   logic [WORD_BITS-1:0] partial_ff, partial_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [WORDS_W-1:0]   remain_ff, remain_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;

   cmd_type              cmd_ff, cmd_in;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [COUNT_W-1:0]   count_ff, count_in;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_status_ff, out_status_in;
   logic                 out_wvalid_ff, out_wvalid_in;
   logic [WORD_BITS-1:0] out_word_ff, out_word_in;
   logic [IDX_W-1:0]     out_index_ff, out_index_in;
   logic [TOTAL_W-1:0]   out_bits_ff, out_bits_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_free;
   logic                 accept;
   logic [TOTAL_W-1:0]   limit;
   logic [TOTAL_W:0]     sum_bits;
   logic                 over;
   logic                 bad_count;
   logic [POS_W-1:0]     pos;
   logic [IDX_W-1:0]     widx;
   logic [COUNT_W:0]     skip_fill;
   logic [WORDS_W-1:0]   skip_words;
   logic [WORD_BITS-1:0] pk_word;
   logic [WORD_BITS-1:0] pk_partial;
   logic                 pk_complete;

   mbp_pack u_pack (
      .partial_word (partial_ff),
      .pos          (pos),
      .value        (value_ff),
      .count        (count_ff[WORDS_W-1:0]),
      .word         (pk_word),
      .next_partial (pk_partial),
      .complete     (pk_complete)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // clamp the limit to the buffer capacity
   assign limit = ({{(CAP_W-TOTAL_W){1'b0}}, max_bits_ff} > CAP_LIMIT)
                  ? CAP_LIMIT[TOTAL_W-1:0] : max_bits_ff;

   assign pos        = total_ff[POS_W-1:0];
   assign widx       = total_ff[POS_W+IDX_W-1:POS_W];
   assign sum_bits   = {1'b0, total_ff} + (TOTAL_W+1)'(count_ff);
   assign over       = sum_bits >= {1'b0, limit};
   assign bad_count  = (count_ff == '0) || (count_ff > COUNT_W'(WORD_BITS));
   assign skip_fill  = (COUNT_W+1)'(pos) + (COUNT_W+1)'(count_ff);
   assign skip_words = skip_fill[COUNT_W:POS_W];

   always_comb begin
      state_in      = state_ff;
      max_bits_in   = csr_write_en ? csr_write_data : max_bits_ff;
      partial_in    = partial_ff;
      total_in      = total_ff;
      remain_in     = remain_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_status_in = out_status_ff;
      out_wvalid_in = out_wvalid_ff;
      out_word_in   = out_word_ff;
      out_index_in  = out_index_ff;
      out_bits_in   = out_bits_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = cmd_type'(req_cmd);
               value_in = req_value;
               count_in = req_bit_count;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // output register is free here: it was free or draining at accept
            out_valid_in  = 1'b1;
            out_status_in = 1'b0;
            out_wvalid_in = 1'b0;
            out_word_in   = '0;
            out_index_in  = '0;
            out_last_in   = 1'b1;
            state_in      = ST_IDLE;
            case (cmd_ff)
               CMD_WRITE: begin
                  if (bad_count || over) begin
                     out_status_in = 1'b1;
                  end else begin
                     total_in   = sum_bits[TOTAL_W-1:0];
                     partial_in = pk_partial;
                     if (pk_complete) begin
                        out_wvalid_in = 1'b1;
                        out_word_in   = pk_word;
                        out_index_in  = widx;
                     end
                  end
               end
               CMD_SKIP: begin
                  if (over) begin
                     out_status_in = 1'b1;
                  end else begin
                     total_in = sum_bits[TOTAL_W-1:0];
                     if (skip_words != '0) begin
                        // first word carries the partial bits, the rest are zero
                        out_wvalid_in = 1'b1;
                        out_word_in   = partial_ff;
                        out_index_in  = widx;
                        out_last_in   = (skip_words == WORDS_W'(1));
                        partial_in    = '0;
                        remain_in     = skip_words - WORDS_W'(1);
                        idx_in        = widx + IDX_W'(1);
                        if (skip_words != WORDS_W'(1)) begin
                           state_in = ST_EMIT;
                        end
                     end
                  end
               end
               CMD_RESET: begin
                  total_in   = '0;
                  partial_in = '0;
               end
               CMD_FLUSH: begin
                  if (pos != '0) begin
                     out_wvalid_in = 1'b1;
                     out_word_in   = partial_ff;
                     out_index_in  = widx;
                  end
               end
               default: begin
                  out_status_in = 1'b0;
               end
            endcase
            out_bits_in = total_in;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = 1'b0;
               out_wvalid_in = 1'b1;
               out_word_in   = '0;
               out_index_in  = idx_ff;
               out_bits_in   = total_ff;
               out_last_in   = (remain_ff == WORDS_W'(1));
               remain_in     = remain_ff - WORDS_W'(1);
               idx_in        = idx_ff + IDX_W'(1);
               if (remain_ff == WORDS_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      count_ff      <= count_in;
      remain_ff     <= remain_in;
      idx_ff        <= idx_in;
      out_status_ff <= out_status_in;
      out_wvalid_ff <= out_wvalid_in;
      out_word_ff   <= out_word_in;
      out_index_ff  <= out_index_in;
      out_bits_ff   <= out_bits_in;
      out_last_ff   <= out_last_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_bits_ff  <= LIMIT_RESET;
         partial_ff   <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_bits_ff  <= max_bits_in;
         partial_ff   <= partial_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_word_valid   = out_wvalid_ff;
   assign rsp_word         = out_word_ff;
   assign rsp_word_index   = out_index_ff;
   assign rsp_bits_written = out_bits_ff;
   assign rsp_last         = out_last_ff;

endmodule

// File: sv/mbp_pack.sv
// ----------------------------------------------------------------------------
// mbp_pack
// Shift and merge unit: places a masked value into a two-word window
// behind the bits already held in the partial word.
// ----------------------------------------------------------------------------
module mbp_pack (
   input  logic [mbp_pkg::WORD_BITS-1:0] partial_word,
   input  logic [mbp_pkg::POS_W-1:0]     pos,
   input  logic [mbp_pkg::WORD_BITS-1:0] value,
   input  logic [mbp_pkg::WORDS_W-1:0]   count,
   output logic [mbp_pkg::WORD_BITS-1:0] word,
   output logic [mbp_pkg::WORD_BITS-1:0] next_partial,
   output logic                          complete
);
   import mbp_pkg::*;

   logic [WORD_BITS-1:0]   masked;
   logic [SHIFT_W-1:0]     fill;
   logic [SHIFT_W-1:0]     shamt;
   logic [2*WORD_BITS-1:0] placed;
   logic [2*WORD_BITS-1:0] merged;

   // a count of a full word shifts the mask out entirely
   assign masked = value & ~({WORD_BITS{1'b1}} << count);
   assign fill   = SHIFT_W'(pos) + SHIFT_W'(count);
   assign shamt  = SHIFT_W'(2 * WORD_BITS) - fill;
   assign placed = {{WORD_BITS{1'b0}}, masked} << shamt;
   assign merged = {partial_word, {WORD_BITS{1'b0}}} | placed;

   assign complete     = fill >= SHIFT_W'(WORD_BITS);
   assign word         = merged[2*WORD_BITS-1:WORD_BITS];
   assign next_partial = complete ? merged[WORD_BITS-1:0]
                                  : merged[2*WORD_BITS-1:WORD_BITS];

endmodule

// File: verif/msb_first_bit_packer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_checker
// Watches both channels and the CSR port of the bit packer. It keeps its own
// copy of the packing state, works out the results that each accepted
// command must produce, and compares every accepted result against them.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_checker #(
   parameter int CAPACITY_BITS = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [mbp_pkg::TOTAL_W-1:0]   csr_write_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [1:0]                    req_cmd,
   input  logic [mbp_pkg::WORD_BITS-1:0] req_value,
   input  logic [mbp_pkg::COUNT_W-1:0]   req_bit_count,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic                          rsp_status,
   input  logic                          rsp_word_valid,
   input  logic [mbp_pkg::WORD_BITS-1:0] rsp_word,
   input  logic [mbp_pkg::IDX_W-1:0]     rsp_word_index,
   input  logic [mbp_pkg::TOTAL_W-1:0]   rsp_bits_written,
   input  logic                          rsp_last,
   output int                            fail_count,
   output int                            pending_results,
   output int                            checked_results
);

   import mbp_pkg::*;

   localparam int MAX_REPORTS = 100;

   typedef struct {
      logic                 status;
      logic                 word_valid;
      logic [WORD_BITS-1:0] word;
      logic [IDX_W-1:0]     word_index;
      logic [TOTAL_W-1:0]   bits_written;
      logic                 last;
   } packed_word_type;

   packed_word_type      expected_words[$];
   logic [WORD_BITS-1:0] fill_word;
   int unsigned          fill_bits;
   logic [TOTAL_W-1:0]   limit_reg;

   initial begin
      fail_count      = 0;
      pending_results = 0;
      checked_results = 0;
      fill_word       = '0;
      fill_bits       = 0;
      limit_reg       = LIMIT_RESET;
   end

   function automatic void queue_word(input logic status, input logic word_valid,
                                      input logic [WORD_BITS-1:0] word,
                                      input int unsigned word_index, input logic last);
      packed_word_type r;
      r.status       = status;
      r.word_valid   = word_valid;
      r.word         = word;
      r.word_index   = word_index[IDX_W-1:0];
      r.bits_written = fill_bits[TOTAL_W-1:0];
      r.last         = last;
      expected_words.push_back(r);
   endfunction

   function automatic void predict_packing(input cmd_type cmd,
                                           input logic [WORD_BITS-1:0] value,
                                           input logic [COUNT_W-1:0] bit_count);
      int unsigned          pos;
      int unsigned          widx;
      int unsigned          lim;
      int unsigned          nbits;
      int unsigned          avail;
      int unsigned          rest;
      int unsigned          words;
      logic [WORD_BITS-1:0] data;
      logic [WORD_BITS-1:0] w;
      pos   = fill_bits % WORD_BITS;
      widx  = fill_bits / WORD_BITS;
      lim   = (limit_reg > CAPACITY_BITS) ? CAPACITY_BITS : limit_reg;
      nbits = bit_count;
      case (cmd)
         CMD_WRITE: begin
            if (nbits == 0 || nbits > WORD_BITS || fill_bits + nbits >= lim) begin
               queue_word(1'b1, 1'b0, '0, 0, 1'b1);
            end else begin
               data  = (nbits < WORD_BITS) ? (value & ((32'd1 << nbits) - 32'd1)) : value;
               avail = WORD_BITS - pos;
               if (nbits < avail) begin
                  fill_word = fill_word | (data << (avail - nbits));
                  fill_bits = fill_bits + nbits;
                  queue_word(1'b0, 1'b0, '0, 0, 1'b1);
               end else begin
                  // the write closes the current word; keep any spill-over
                  rest = nbits - avail;
                  if (rest == 0) begin
                     w         = fill_word | data;
                     fill_word = '0;
                  end else begin
                     w         = fill_word | (data >> rest);
                     fill_word = data << (WORD_BITS - rest);
                  end
                  fill_bits = fill_bits + nbits;
                  queue_word(1'b0, 1'b1, w, widx, 1'b1);
               end
            end
         end
         CMD_SKIP: begin
            if (fill_bits + nbits >= lim) begin
               queue_word(1'b1, 1'b0, '0, 0, 1'b1);
            end else begin
               words     = (pos + nbits) / WORD_BITS;
               fill_bits = fill_bits + nbits;
               if (words == 0) begin
                  queue_word(1'b0, 1'b0, '0, 0, 1'b1);
               end else begin
                  // first word carries the partial bits, the rest are zero
                  for (int unsigned k = 0; k < words; k++) begin
                     queue_word(1'b0, 1'b1, (k == 0) ? fill_word : '0, widx + k,
                                k + 1 == words);
                  end
                  fill_word = '0;
               end
            end
         end
         CMD_RESET: begin
            fill_word = '0;
            fill_bits = 0;
            queue_word(1'b0, 1'b0, '0, 0, 1'b1);
         end
         default: begin
            if (pos != 0) begin
               queue_word(1'b0, 1'b1, fill_word, widx, 1'b1);
            end else begin
               queue_word(1'b0, 1'b0, '0, 0, 1'b1);
            end
         end
      endcase
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
         end
      end
   endtask

   always @(posedge clock) begin
      packed_word_type want;
      if (reset) begin
         fill_word = '0;
         fill_bits = 0;
         limit_reg = LIMIT_RESET;
         expected_words.delete();
      end else begin
         if (csr_write_en) begin
            limit_reg = csr_write_data;
         end
         // compare before predicting: a result never belongs to this edge's command
         if (rsp_valid && !rsp_stall) begin
            checked_results++;
            if (expected_words.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t ns: unexpected transaction, expected none, actual word %h index %0d",
                           $time, rsp_word, rsp_word_index);
               end
            end else begin
               want = expected_words.pop_front();
               compare_field("status",       want.status,       rsp_status);
               compare_field("word_valid",   want.word_valid,   rsp_word_valid);
               compare_field("word",         want.word,         rsp_word);
               compare_field("word_index",   want.word_index,   rsp_word_index);
               compare_field("bits_written", want.bits_written, rsp_bits_written);
               compare_field("last",         want.last,         rsp_last);
            end
         end
         if (req_valid && !req_stall) begin
            predict_packing(cmd_type'(req_cmd), req_value, req_bit_count);
         end
      end
      pending_results = expected_words.size();
   end

endmodule

// File: verif/msb_first_bit_packer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_tb
// Drives write, skip, reset and flush commands into the bit packer under a
// range of capacity limits: first a directed run over the corner cases, then
// random phases with bursty gaps and output stalls. The checker alongside
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_tb;

   import mbp_pkg::*;

   localparam int CAPACITY_BITS = 65536;
   localparam int PHASE_ITEMS   = 28;
   localparam int SETTLE_CYCLES = 40;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [TOTAL_W-1:0]    csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_cmd;
   logic [WORD_BITS-1:0]  req_value;
   logic [COUNT_W-1:0]    req_bit_count;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_status;
   logic                  rsp_word_valid;
   logic [WORD_BITS-1:0]  rsp_word;
   logic [IDX_W-1:0]      rsp_word_index;
   logic [TOTAL_W-1:0]    rsp_bits_written;
   logic                  rsp_last;

   int                    fail_count;
   int                    pending_results;
   int                    checked_results;
   int                    commands_sent;
   int                    limits_used;
   bit                    idling;
   int                    stall_left;

   logic [TOTAL_W-1:0]    random_limits[7] = '{17'd131071, 17'd300, 17'd1000, 17'd65536,
                                               17'd1, 17'd2048, 17'd65536};

   msb_first_bit_packer #(
      .CAPACITY_BITS(CAPACITY_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_word_valid  (rsp_word_valid),
      .rsp_word        (rsp_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_bits_written(rsp_bits_written),
      .rsp_last        (rsp_last)
   );

   msb_first_bit_packer_checker #(
      .CAPACITY_BITS(CAPACITY_BITS)
   ) i_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_bit_count   (req_bit_count),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_word_valid  (rsp_word_valid),
      .rsp_word        (rsp_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_bits_written(rsp_bits_written),
      .rsp_last        (rsp_last),
      .fail_count      (fail_count),
      .pending_results (pending_results),
      .checked_results (checked_results)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // output back-pressure in random bursts
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall = 1'b1;
         end else if (idling && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_stall  = 1'b1;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   initial begin
      #20_000_000;
      $display("Timed out waiting for the packer");
      $display("== FAIL ==");
      $finish;
   end

   // all tasks start and end on a falling edge
   task automatic send_command(input cmd_type cmd, input logic [WORD_BITS-1:0] value,
                               input logic [COUNT_W-1:0] bit_count);
      int gap;
      if (idling && $urandom_range(0, 4) == 0) begin
         gap       = $urandom_range(1, 17);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_cmd       = cmd;
      req_value     = value;
      req_bit_count = bit_count;
      req_valid     = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      commands_sent++;
   endtask

   task automatic drain_and_set_limit(input logic [TOTAL_W-1:0] limit);
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en   = 1'b1;
      csr_write_data = limit;
      @(negedge clock);
      csr_write_en   = 1'b0;
      limits_used++;
   endtask

   task automatic send_random_command();
      int pick;
      int unsigned count;
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         send_command(CMD_WRITE, $urandom(), COUNT_W'($urandom_range(1, 32)));
      end else if (pick < 67) begin
         count = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(33, 1023);
         send_command(CMD_WRITE, $urandom(), COUNT_W'(count));
      end else if (pick < 83) begin
         count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
         send_command(CMD_SKIP, $urandom(), COUNT_W'(count));
      end else if (pick < 95) begin
         send_command(CMD_FLUSH, $urandom(), COUNT_W'($urandom_range(0, 1023)));
      end else begin
         send_command(CMD_RESET, $urandom(), COUNT_W'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      req_valid      = 1'b0;
      req_cmd        = CMD_WRITE;
      req_value      = '0;
      req_bit_count  = '0;
      idling         = 1'b1;
      commands_sent  = 0;
      limits_used    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // oversized limit: masking, bad counts, flushes, longest skip
      drain_and_set_limit(17'd131071);
      send_command(CMD_WRITE, 32'hFFFF_FFFF, 10'd1);
      send_command(CMD_WRITE, 32'hFFFF_FFFF, 10'd32);
      send_command(CMD_WRITE, 32'h0000_0000, 10'd0);
      send_command(CMD_WRITE, 32'h0000_FFFF, 10'd33);
      send_command(CMD_WRITE, 32'h0000_0000, 10'd1023);
      send_command(CMD_FLUSH, 32'h0, 10'd0);
      send_command(CMD_FLUSH, 32'h0, 10'd0);
      send_command(CMD_WRITE, 32'hA5A5_A5A5, 10'd31);
      send_command(CMD_FLUSH, 32'h0, 10'd0);
      send_command(CMD_SKIP,  32'h0, 10'd0);
      send_command(CMD_WRITE, 32'h7FFF_FFFF, 10'd31);
      send_command(CMD_SKIP,  32'hFFFF_FFFF, 10'd1023);
      send_command(CMD_RESET, 32'h0, 10'd0);

      // tight limit: writes and skips right at the edge
      drain_and_set_limit(17'd40);
      send_command(CMD_WRITE, 32'h1234_5678, 10'd32);
      send_command(CMD_WRITE, 32'h0000_00FF, 10'd8);
      send_command(CMD_WRITE, 32'h0000_0055, 10'd7);
      send_command(CMD_SKIP,  32'h0, 10'd0);
      send_command(CMD_SKIP,  32'h0, 10'd1);
      send_command(CMD_RESET, 32'h0, 10'd0);

      // zero limit rejects everything that appends
      drain_and_set_limit(17'd0);
      send_command(CMD_WRITE, 32'h1, 10'd1);
      send_command(CMD_SKIP,  32'h0, 10'd0);
      send_command(CMD_FLUSH, 32'h0, 10'd0);

      // lower the limit below the bits already written, then recover
      drain_and_set_limit(17'd65536);
      send_command(CMD_RESET, 32'h0, 10'd0);
      send_command(CMD_SKIP,  32'h0, 10'd500);
      drain_and_set_limit(17'd100);
      send_command(CMD_WRITE, 32'h3, 10'd2);
      send_command(CMD_SKIP,  32'h0, 10'd1);
      send_command(CMD_RESET, 32'h0, 10'd0);
      send_command(CMD_WRITE, 32'h3, 10'd2);

      foreach (random_limits[p]) begin
         drain_and_set_limit(random_limits[p]);
         // keep one phase and the tail of the run free of gaps
         idling = (p != 2) && (p != $size(random_limits) - 1);
         repeat (PHASE_ITEMS) send_random_command();
      end

      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Sent %0d commands under %0d capacity limits, checked %0d results",
               commands_sent, limits_used, checked_results);
      if (fail_count == 0 && pending_results == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/mbp_pkg.sv
sv/mbp_pack.sv
sv/msb_first_bit_packer.sv
verif/msb_first_bit_packer_checker.sv
verif/msb_first_bit_packer_tb.sv
